// ===== rtl/core/fifo_handle_pool_allocator_assert.svh =====
// ---------------------------------------------------------------------------
// fifo_handle_pool_allocator assertion macros
// shared forms for the concurrent checks of the handle pool
// ---------------------------------------------------------------------------
`ifndef FIFO_HANDLE_POOL_ALLOCATOR_ASSERT_SVH
`define FIFO_HANDLE_POOL_ALLOCATOR_ASSERT_SVH

// same-cycle implication, off during reset
`define FHPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define FHPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fhpa_pkg.sv =====
// ---------------------------------------------------------------------------
// fhpa_pkg
// types and constants shared by the handle pool allocator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fhpa_pkg;

    localparam int POOL_SIZE   = 64;
    localparam int HANDLE_W    = 6;
    localparam int COUNT_W     = 7;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0]
    {
        OP_ALLOC = 2'd0,
        OP_TRY   = 2'd1,
        OP_FREE  = 2'd2
    } op_e;

    typedef enum logic [1:0]
    {
        ST_OK         = 2'd0,
        ST_NONE_FREED = 2'd1,
        ST_EXHAUSTED  = 2'd2,
        ST_INVALID    = 2'd3
    } status_e;

    // operation class after decode in the front end
    typedef enum logic [1:0]
    {
        K_ALLOC = 2'd0,
        K_TRY   = 2'd1,
        K_FREE  = 2'd2,
        K_BAD   = 2'd3
    } kind_e;

    typedef struct packed
    {
        logic [1:0]          operation;
        logic [HANDLE_W-1:0] release_handle;
    } req_t;

    typedef struct packed
    {
        logic [HANDLE_W-1:0] granted_handle;
        logic [1:0]          status;
    } rsp_t;

    typedef struct packed
    {
        kind_e               kind;
        logic [HANDLE_W-1:0] handle;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/fhpa_ram.sv =====
// ---------------------------------------------------------------------------
// fhpa_ram
// simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fhpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fhpa_front.sv =====
// ---------------------------------------------------------------------------
// fhpa_front
// accepts requests, decodes the operation and queues commands for the back end
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fhpa_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  fhpa_pkg::req_t req,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output fhpa_pkg::cmd_t cmd
);

    import fhpa_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    cmd_t             q_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;
    cmd_t             dec;
    logic             push, pop;

    always_comb
    begin
        dec.handle = req.release_handle;
        case (req.operation)
            OP_ALLOC: dec.kind = K_ALLOC;
            OP_TRY:   dec.kind = K_TRY;
            OP_FREE:  dec.kind = K_FREE;
            default:  dec.kind = K_BAD;
        endcase
    end

    assign req_ready = (cnt_reg != (PTR_W+1)'(QUEUE_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = req_valid && req_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fhpa_back.sv =====
// ---------------------------------------------------------------------------
// fhpa_back
// executes pool commands: freed-handle fifo, fresh counter, allocated bitmap
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fhpa_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  fhpa_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output fhpa_pkg::rsp_t rsp
);

    import fhpa_pkg::*;

    typedef enum logic [1:0]
    {
        S_EXEC = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t                state_reg, state_next;
    logic [HANDLE_W-1:0]   head_reg, head_next;
    logic [HANDLE_W-1:0]   tail_reg, tail_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [COUNT_W-1:0]    fresh_reg, fresh_next;
    logic [POOL_SIZE-1:0]  map_reg, map_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg, rsp_next;

    logic                  out_free, cmd_fire, load;
    logic                  ram_wr_en, ram_rd_en;
    logic [HANDLE_W-1:0]   ram_rd_data;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign cmd_ready = (state_reg == S_EXEC) && out_free;
    assign cmd_fire  = cmd_valid && cmd_ready;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        fresh_next = fresh_reg;
        map_next   = map_reg;
        rsp_next   = rsp_reg;
        load       = 1'b0;
        ram_wr_en  = 1'b0;
        ram_rd_en  = 1'b0;

        case (state_reg)
            S_EXEC:
            begin
                if (cmd_fire)
                begin
                    case (cmd.kind)
                        K_ALLOC, K_TRY:
                        begin
                            if (count_reg != '0)
                            begin
                                // oldest freed handle comes back from the ram next cycle
                                ram_rd_en  = 1'b1;
                                state_next = S_READ;
                            end
                            else if (cmd.kind == K_ALLOC && fresh_reg < COUNT_W'(POOL_SIZE))
                            begin
                                load                    = 1'b1;
                                rsp_next.granted_handle = fresh_reg[HANDLE_W-1:0];
                                rsp_next.status         = ST_OK;
                                map_next[fresh_reg[HANDLE_W-1:0]] = 1'b1;
                                fresh_next              = fresh_reg + 1'b1;
                            end
                            else
                            begin
                                load                    = 1'b1;
                                rsp_next.granted_handle = '0;
                                rsp_next.status = (cmd.kind == K_ALLOC) ? ST_EXHAUSTED
                                                                        : ST_NONE_FREED;
                            end
                        end
                        K_FREE:
                        begin
                            load                    = 1'b1;
                            rsp_next.granted_handle = '0;
                            if (map_reg[cmd.handle] && count_reg < COUNT_W'(POOL_SIZE))
                            begin
                                rsp_next.status       = ST_OK;
                                ram_wr_en             = 1'b1;
                                map_next[cmd.handle]  = 1'b0;
                                count_next            = count_reg + 1'b1;
                                tail_next = (tail_reg == HANDLE_W'(POOL_SIZE-1)) ? '0
                                                                                : tail_reg + 1'b1;
                            end
                            else
                            begin
                                rsp_next.status = ST_INVALID;
                            end
                        end
                        default:
                        begin
                            load                    = 1'b1;
                            rsp_next.granted_handle = '0;
                            rsp_next.status         = ST_INVALID;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    load                    = 1'b1;
                    rsp_next.granted_handle = ram_rd_data;
                    rsp_next.status         = ST_OK;
                    map_next[ram_rd_data]   = 1'b1;
                    count_next              = count_reg - 1'b1;
                    head_next  = (head_reg == HANDLE_W'(POOL_SIZE-1)) ? '0 : head_reg + 1'b1;
                    state_next = S_EXEC;
                end
            end
            default:
            begin
                state_next = S_EXEC;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_EXEC;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            fresh_reg     <= '0;
            map_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
            map_reg       <= map_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    fhpa_ram #(
        .WIDTH (HANDLE_W),
        .DEPTH (POOL_SIZE)
    ) u_free_fifo (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail_reg),
        .wr_data (cmd.handle),
        .rd_en   (ram_rd_en),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fifo_handle_pool_allocator.sv =====
// ---------------------------------------------------------------------------
// fifo_handle_pool_allocator
// pool of 64 numbered handles with a freed-handle fifo and allocated bitmap
// ---------------------------------------------------------------------------
// usage
//   req channel: operation (allocate, try-allocate, deallocate) and the
//   handle to release; rsp channel: granted handle and status, one rsp per
//   request, in request order. both channels are valid/ready.
//   a request is first queued in a two-entry command queue, then executed.
//   response: rsp_valid is registered; deallocate, fresh allocate and every
//   refused request answer from the execute state, a freed-fifo pop passes
//   a read state first (registered ram read port). throughput: one request
//   per cycle when rsp is not stalled, none while a freed-fifo pop is read.
//   reset: head, tail, counters and the 64-bit allocated bitmap clear at
//   once; the freed-fifo ram is not cleared, it is only read after a write,
//   so the block takes requests right after reset.
//   stall: the rsp register holds while rsp_ready is low; the command queue
//   keeps taking requests until it fills, then req_ready drops.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fifo_handle_pool_allocator (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  fhpa_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output fhpa_pkg::rsp_t rsp
);

    import fhpa_pkg::*;

    logic cmd_valid, cmd_ready;
    cmd_t cmd;

    fhpa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    fhpa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ===== rtl/core/fhpa_checker.sv =====
// ---------------------------------------------------------------------------
// fhpa_checker
// port-level checks of the handle pool allocator, bound to the top level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fifo_handle_pool_allocator_assert.svh"

module fhpa_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input fhpa_pkg::req_t req,
    input logic           rsp_valid,
    input logic           rsp_ready,
    input fhpa_pkg::rsp_t rsp
);

    import fhpa_pkg::*;

    logic rsp_stall;
    logic req_stall;
    logic rsp_refused;

    assign rsp_stall   = rsp_valid && !rsp_ready;
    assign req_stall   = req_valid && !req_ready;
    assign rsp_refused = rsp_valid && rsp.status != ST_OK;

    // a stalled rsp keeps its payload
    `FHPA_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp), "rsp moved while stalled")

    // a waiting request keeps its payload
    `FHPA_ASSERT_NEXT(a_req_hold, req_stall, req_valid && $stable(req), "req moved while stalled")

    // a refused request carries handle zero; only a successful allocate can carry a nonzero handle
    `FHPA_ASSERT_NOW(a_handle_zero, rsp_refused, rsp.granted_handle == '0, "handle on a refusal")

    // nothing can be answered in the first cycle out of reset
    `FHPA_ASSERT_NOW(a_no_rsp_at_reset, !$past(rst_n), !rsp_valid, "rsp right after reset")

    // a request is queued before its rsp, so none shows beside a request in the first cycle out of reset
    `FHPA_ASSERT_NOW(a_req_latency, $past(!rst_n) && req_valid, !rsp_valid, "rsp with first req")

endmodule

bind fifo_handle_pool_allocator fhpa_checker u_checker (.*);

`default_nettype wire
